// ===== sv/ppsup_pkg.sv =====
// shared types, constants and register codes of the pump protection supervisor
`timescale 1ns / 1ps

package ppsup_pkg;

  localparam int ADC_BITS   = 12;
  localparam int TANK_CFG_W = 12;
  localparam int TANK_CMP_W = (ADC_BITS > TANK_CFG_W) ? ADC_BITS : TANK_CFG_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RATE_W     = 10;
  localparam int FLOW_W     = RATE_W + 32;

  localparam logic [15:0] FLOW_SCALE      = 16'd60000;
  localparam logic [31:0] DEFAULT_ELAPSED = 32'd1000;

  localparam logic [15:0]         RST_GRACE       = 16'd3000;
  localparam logic [15:0]         RST_DRY_TIMEOUT = 16'd8000;
  localparam logic [15:0]         RST_STK_TIMEOUT = 16'd5000;
  localparam logic [RATE_W-1:0]   RST_MIN_RATE    = 10'd135;
  localparam logic [RATE_W-1:0]   RST_STK_RATE    = 10'd225;
  localparam logic [TANK_CFG_W-1:0] RST_TANK_LOW  = 12'd992;

  localparam logic [1:0] TF_LEVEL  = 2'b01;
  localparam logic [1:0] TF_SWITCH = 2'b10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRYRUN_GRACE   = 3'd0,
    REG_DRYRUN_TIMEOUT = 3'd1,
    REG_STUCK_TIMEOUT  = 3'd2,
    REG_MIN_FLOW_RATE  = 3'd3,
    REG_STUCK_FLOW     = 3'd4,
    REG_TANK_LOW_RAW   = 3'd5,
    REG_TANK_MODE      = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_CMD  = 1'b1
  } req_t;

  typedef struct packed {
    logic                req_type;
    logic [31:0]         now_ms;
    logic [31:0]         elapsed_ms;
    logic [15:0]         pulses_pump1;
    logic [15:0]         pulses_pump2;
    logic [ADC_BITS-1:0] tank_raw;
    logic                tank_switch_low;
    logic                pump_select;
    logic                pump_on;
  } in_t;

  typedef struct packed {
    logic        pump1_relay_on;
    logic        pump2_relay_on;
    logic [2:0]  pump1_status;
    logic [2:0]  pump2_status;
    logic [1:0]  tank_flags;
    logic        system_error;
    logic [31:0] pump1_total_pulses;
    logic [31:0] pump2_total_pulses;
  } out_t;

  typedef struct packed {
    logic [15:0] grace;
    logic [15:0] dry_timeout;
    logic [15:0] stuck_timeout;
  } pump_cfg_t;

  typedef struct packed {
    logic        step;
    logic        tick;
    logic        cmd_hit;
    logic        cmd_on;
    logic        tank_low;
    logic        below;
    logic        above;
    logic [15:0] pulses;
    logic [31:0] now;
  } pump_ctl_t;

  typedef struct packed {
    logic        relay;
    logic        dry;
    logic        stuck;
    logic [31:0] total;
  } pump_res_t;

endpackage

// ===== sv/pump_protection_supervisor.sv =====
// top level of the two-pump protection supervisor
`timescale 1ns / 1ps

// Two-pump protection supervisor. Each input beat is a tick with sensor data or
// an on/off command; each gives exactly one result beat with relay drives,
// status, tank flags, the error flag and the saturating pulse totals. A beat is
// taken into an input register, worked through combinationally (flow compare,
// interlock, dry-run and stuck detection, relay follow) and the result lands in
// an output register, so the result beat is offered from the output register
// and one beat per cycle is sustained while out_ready stays high; the per-pump
// state update is written when the result is registered. Configuration writes go through cfg_we, cfg_index
// and cfg_data and must be made while idle.
// Indexes past the register list are ignored. No clearing pass after reset.
module pump_protection_supervisor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ppsup_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ppsup_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [ppsup_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppsup_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppsup_pkg::*;

  logic [15:0]           grace_ms;
  logic [15:0]           dry_limit_ms;
  logic [15:0]           stuck_timeout_ms;
  logic [RATE_W-1:0]     min_flow_rate;
  logic [RATE_W-1:0]     stuck_flow_rate;
  logic [TANK_CFG_W-1:0] tank_low_raw;
  logic                  float_mode;

  in_t        item;
  logic       item_valid;
  logic [1:0] tank_flag_bits, tank_flag_bits_next;
  logic       advance, step, is_tick, tank_low, error_next;
  logic       below1, above1, below2, above2;
  pump_cfg_t  pcfg;
  pump_ctl_t  ctl1, ctl2;
  pump_res_t  res1, res2;
  logic [TANK_CMP_W-1:0] raw_w, low_w;

  assign advance  = !out_valid || out_ready;
  assign step     = item_valid && advance;
  assign in_ready = !item_valid || advance;
  assign is_tick  = (item.req_type == REQ_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_ms          <= RST_GRACE;
      dry_limit_ms      <= RST_DRY_TIMEOUT;
      stuck_timeout_ms  <= RST_STK_TIMEOUT;
      min_flow_rate     <= RST_MIN_RATE;
      stuck_flow_rate   <= RST_STK_RATE;
      tank_low_raw      <= RST_TANK_LOW;
      float_mode        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRYRUN_GRACE:   grace_ms          <= cfg_data;
        REG_DRYRUN_TIMEOUT: dry_limit_ms      <= cfg_data;
        REG_STUCK_TIMEOUT:  stuck_timeout_ms  <= cfg_data;
        REG_MIN_FLOW_RATE:  min_flow_rate     <= cfg_data[RATE_W-1:0];
        REG_STUCK_FLOW:     stuck_flow_rate   <= cfg_data[RATE_W-1:0];
        REG_TANK_LOW_RAW:   tank_low_raw      <= cfg_data[TANK_CFG_W-1:0];
        REG_TANK_MODE:      float_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  ppsup_flow u_flow1 (
    .pulses     (item.pulses_pump1),
    .elapsed    (item.elapsed_ms),
    .min_rate   (min_flow_rate),
    .stuck_rate (stuck_flow_rate),
    .below      (below1),
    .above      (above1)
  );

  ppsup_flow u_flow2 (
    .pulses     (item.pulses_pump2),
    .elapsed    (item.elapsed_ms),
    .min_rate   (min_flow_rate),
    .stuck_rate (stuck_flow_rate),
    .below      (below2),
    .above      (above2)
  );

  always_comb begin
    raw_w = {{(TANK_CMP_W-ADC_BITS){1'b0}}, item.tank_raw};
    low_w = {{(TANK_CMP_W-TANK_CFG_W){1'b0}}, tank_low_raw};
    tank_flag_bits_next = tank_flag_bits;
    if (is_tick) begin
      if (float_mode) begin
        tank_flag_bits_next = item.tank_switch_low ? TF_SWITCH : 2'b00;
      end else begin
        tank_flag_bits_next = (raw_w <= low_w) ? TF_LEVEL : 2'b00;
      end
    end
    tank_low = |tank_flag_bits_next;

    pcfg.grace         = grace_ms;
    pcfg.dry_timeout   = dry_limit_ms;
    pcfg.stuck_timeout = stuck_timeout_ms;

    ctl1.step     = step;
    ctl1.tick     = is_tick;
    ctl1.cmd_hit  = !is_tick && !item.pump_select;
    ctl1.cmd_on   = item.pump_on;
    ctl1.tank_low = tank_low;
    ctl1.below    = below1;
    ctl1.above    = above1;
    ctl1.pulses   = item.pulses_pump1;
    ctl1.now      = item.now_ms;

    ctl2.step     = step;
    ctl2.tick     = is_tick;
    ctl2.cmd_hit  = !is_tick && item.pump_select;
    ctl2.cmd_on   = item.pump_on;
    ctl2.tank_low = tank_low;
    ctl2.below    = below2;
    ctl2.above    = above2;
    ctl2.pulses   = item.pulses_pump2;
    ctl2.now      = item.now_ms;

    error_next = tank_low || res1.dry || res1.stuck || res2.dry || res2.stuck;
  end

  ppsup_pump u_pump1 (
    .clk (clk),
    .rst (rst),
    .cfg (pcfg),
    .ctl (ctl1),
    .res (res1)
  );

  ppsup_pump u_pump2 (
    .clk (clk),
    .rst (rst),
    .cfg (pcfg),
    .ctl (ctl2),
    .res (res2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tank_flag_bits <= 2'b00;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        tank_flag_bits <= tank_flag_bits_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      out_data.pump1_relay_on     <= res1.relay;
      out_data.pump2_relay_on     <= res2.relay;
      out_data.pump1_status       <= {res1.stuck, res1.dry, res1.relay};
      out_data.pump2_status       <= {res2.stuck, res2.dry, res2.relay};
      out_data.tank_flags         <= tank_flag_bits_next;
      out_data.system_error       <= error_next;
      out_data.pump1_total_pulses <= res1.total;
      out_data.pump2_total_pulses <= res2.total;
    end
  end

endmodule

// ===== sv/ppsup_flow.sv =====
// flow rate compare of one pump: pulses*60000 against rate*elapsed
`timescale 1ns / 1ps

module ppsup_flow (
  input  logic [15:0]                 pulses,
  input  logic [31:0]                 elapsed,
  input  logic [ppsup_pkg::RATE_W-1:0] min_rate,
  input  logic [ppsup_pkg::RATE_W-1:0] stuck_rate,
  output logic                        below,
  output logic                        above
);
  import ppsup_pkg::*;

  logic [31:0]       el;
  logic [31:0]       lhs;
  logic [FLOW_W-1:0] lhs_w;
  logic [FLOW_W-1:0] min_rhs;
  logic [FLOW_W-1:0] stk_rhs;

  always_comb begin
    el      = (elapsed == 32'd0) ? DEFAULT_ELAPSED : elapsed;
    lhs     = {16'd0, pulses} * {16'd0, FLOW_SCALE};
    lhs_w   = {{(FLOW_W-32){1'b0}}, lhs};
    min_rhs = {{(FLOW_W-RATE_W){1'b0}}, min_rate} * {{(FLOW_W-32){1'b0}}, el};
    stk_rhs = {{(FLOW_W-RATE_W){1'b0}}, stuck_rate} * {{(FLOW_W-32){1'b0}}, el};
    below   = lhs_w < min_rhs;
    above   = lhs_w > stk_rhs;
  end

endmodule

// ===== sv/ppsup_pump.sv =====
// per-pump state: dry-run latch, relay-stuck detector, relay follow and pulse total
`timescale 1ns / 1ps

module ppsup_pump (
  input  logic                  clk,
  input  logic                  rst,
  input  ppsup_pkg::pump_cfg_t  cfg,
  input  ppsup_pkg::pump_ctl_t  ctl,
  output ppsup_pkg::pump_res_t  res
);
  import ppsup_pkg::*;

  logic        want_on, want_on_next;
  logic        relay_state, relay_state_next;
  logic        dry_run_flag, dry_run_flag_next;
  logic        stuck_flag, stuck_flag_next;
  logic [31:0] on_since, on_since_next;
  logic [31:0] low_flow_since, low_flow_since_next;
  logic [31:0] off_flow_since, off_flow_since_next;
  logic [31:0] pulse_total, pulse_total_next;
  logic        flow_below_min, flow_below_min_next;
  logic        flow_above_stuck, flow_above_stuck_next;

  logic [32:0] sum;
  logic [31:0] lfs, ofs;
  logic        want_j;

  always_comb begin
    sum                   = {1'b0, pulse_total} + {17'd0, ctl.pulses};
    flow_below_min_next   = ctl.tick ? ctl.below : flow_below_min;
    flow_above_stuck_next = ctl.tick ? ctl.above : flow_above_stuck;
    pulse_total_next      = pulse_total;
    if (ctl.tick) begin
      pulse_total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    want_j = ctl.cmd_hit ? ctl.cmd_on : want_on;
    if (ctl.tank_low) begin
      want_j = 1'b0;
    end

    dry_run_flag_next   = dry_run_flag;
    stuck_flag_next     = stuck_flag;
    low_flow_since_next = low_flow_since;
    off_flow_since_next = off_flow_since;
    on_since_next       = on_since;
    lfs                 = (low_flow_since == 32'd0) ? ctl.now : low_flow_since;
    ofs                 = (off_flow_since == 32'd0) ? ctl.now : off_flow_since;

    if (relay_state) begin
      if ((ctl.now - on_since) >= {16'd0, cfg.grace}) begin
        if (flow_below_min_next) begin
          low_flow_since_next = lfs;
          if ((ctl.now - lfs) >= {16'd0, cfg.dry_timeout}) begin
            dry_run_flag_next = 1'b1;
            want_j            = 1'b0;
          end
        end else begin
          low_flow_since_next = 32'd0;
          dry_run_flag_next   = 1'b0;
        end
      end
      off_flow_since_next = 32'd0;
      stuck_flag_next     = 1'b0;
    end else begin
      low_flow_since_next = 32'd0;
      if (flow_above_stuck_next) begin
        off_flow_since_next = ofs;
        if ((ctl.now - ofs) >= {16'd0, cfg.stuck_timeout}) begin
          stuck_flag_next = 1'b1;
        end
      end else begin
        off_flow_since_next = 32'd0;
        stuck_flag_next     = 1'b0;
      end
    end

    // relay follows the request, timestamps restart on each change
    want_on_next     = want_j;
    relay_state_next = relay_state;
    if (want_j != relay_state) begin
      relay_state_next = want_j;
      if (want_j) begin
        on_since_next       = ctl.now;
        low_flow_since_next = 32'd0;
      end else begin
        off_flow_since_next = 32'd0;
      end
    end

    res.relay = relay_state_next;
    res.dry   = dry_run_flag_next;
    res.stuck = stuck_flag_next;
    res.total = pulse_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      want_on          <= 1'b0;
      relay_state      <= 1'b0;
      dry_run_flag     <= 1'b0;
      stuck_flag       <= 1'b0;
      on_since         <= 32'd0;
      low_flow_since   <= 32'd0;
      off_flow_since   <= 32'd0;
      pulse_total      <= 32'd0;
      flow_below_min   <= 1'b1;
      flow_above_stuck <= 1'b0;
    end else if (ctl.step) begin
      want_on          <= want_on_next;
      relay_state      <= relay_state_next;
      dry_run_flag     <= dry_run_flag_next;
      stuck_flag       <= stuck_flag_next;
      on_since         <= on_since_next;
      low_flow_since   <= low_flow_since_next;
      off_flow_since   <= off_flow_since_next;
      pulse_total      <= pulse_total_next;
      flow_below_min   <= flow_below_min_next;
      flow_above_stuck <= flow_above_stuck_next;
    end
  end

endmodule

// ===== tb/sv/pump_supervisor_check.sv =====
// checker of the pump protection supervisor: predicts each result beat and compares it
`timescale 1ns / 1ps

module pump_supervisor_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  ppsup_pkg::in_t                   in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  ppsup_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [ppsup_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppsup_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               pending,
  output int                               fails
);
  import ppsup_pkg::*;

  localparam logic [2:0] ST_ON    = 3'b001;
  localparam logic [2:0] ST_DRY   = 3'b010;
  localparam logic [2:0] ST_STUCK = 3'b100;

  // registers as the block holds them
  logic [15:0]           grace_ms, dry_ms, stuck_ms;
  logic [RATE_W-1:0]     min_rate, stuck_rate;
  logic [TANK_CFG_W-1:0] tank_low;
  logic                  tank_by_switch;

  // per-pump supervision state
  logic        want_on [2];
  logic        relay [2];
  logic        dry [2];
  logic        stuck [2];
  logic [31:0] on_at [2];
  logic [31:0] lowflow_at [2];
  logic [31:0] offflow_at [2];
  logic [31:0] total [2];
  logic        below [2];
  logic        above [2];
  logic [1:0]  tank_bits;

  out_t status_due [$];
  out_t oldest;

  task automatic clear_state();
    grace_ms       = RST_GRACE;
    dry_ms         = RST_DRY_TIMEOUT;
    stuck_ms       = RST_STK_TIMEOUT;
    min_rate       = RST_MIN_RATE;
    stuck_rate     = RST_STK_RATE;
    tank_low       = RST_TANK_LOW;
    tank_by_switch = 1'b0;
    for (int k = 0; k < 2; k++) begin
      want_on[k]    = 1'b0;
      relay[k]      = 1'b0;
      dry[k]        = 1'b0;
      stuck[k]      = 1'b0;
      on_at[k]      = '0;
      lowflow_at[k] = '0;
      offflow_at[k] = '0;
      total[k]      = '0;
      below[k]      = 1'b1;
      above[k]      = 1'b0;
    end
    tank_bits = '0;
  endtask

  function automatic logic [2:0] status_bits(input int k);
    return (relay[k] ? ST_ON : 3'b000) | (dry[k] ? ST_DRY : 3'b000) |
           (stuck[k] ? ST_STUCK : 3'b000);
  endfunction

  // one beat through the supervisor: flow marks, interlock, latches, relay follow
  function automatic out_t supervise(input in_t b);
    out_t        r;
    logic [31:0] el;
    logic [15:0] p [2];
    logic [63:0] lhs;
    logic [32:0] sum;
    logic [31:0] age;
    logic        err;
    p[0] = b.pulses_pump1;
    p[1] = b.pulses_pump2;
    if (b.req_type == REQ_TICK) begin
      el = (b.elapsed_ms == 32'd0) ? DEFAULT_ELAPSED : b.elapsed_ms;
      if (tank_by_switch)
        tank_bits = b.tank_switch_low ? TF_SWITCH : 2'b00;
      else
        tank_bits = (b.tank_raw <= tank_low) ? TF_LEVEL : 2'b00;
      for (int k = 0; k < 2; k++) begin
        lhs      = 64'(p[k]) * 64'(FLOW_SCALE);
        below[k] = lhs < 64'(min_rate) * 64'(el);
        above[k] = lhs > 64'(stuck_rate) * 64'(el);
        sum      = {1'b0, total[k]} + 33'(p[k]);
        total[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end else begin
      want_on[b.pump_select] = b.pump_on;
    end

    err = 1'b0;
    if (tank_bits != 2'b00) begin
      want_on[0] = 1'b0;
      want_on[1] = 1'b0;
      err = 1'b1;
    end

    for (int k = 0; k < 2; k++) begin
      if (relay[k]) begin
        age = b.now_ms - on_at[k];
        if (age >= 32'(grace_ms)) begin
          if (below[k]) begin
            // zero marks an unset timestamp
            if (lowflow_at[k] == 32'd0) lowflow_at[k] = b.now_ms;
            age = b.now_ms - lowflow_at[k];
            if (age >= 32'(dry_ms)) begin
              dry[k]     = 1'b1;
              want_on[k] = 1'b0;
            end
          end else begin
            lowflow_at[k] = '0;
            dry[k]        = 1'b0;
          end
        end
        offflow_at[k] = '0;
        stuck[k]      = 1'b0;
      end else begin
        lowflow_at[k] = '0;
        if (above[k]) begin
          if (offflow_at[k] == 32'd0) offflow_at[k] = b.now_ms;
          age = b.now_ms - offflow_at[k];
          if (age >= 32'(stuck_ms)) stuck[k] = 1'b1;
        end else begin
          offflow_at[k] = '0;
          stuck[k]      = 1'b0;
        end
      end
    end
    if (dry[0] || stuck[0] || dry[1] || stuck[1]) err = 1'b1;

    for (int k = 0; k < 2; k++) begin
      if (want_on[k] != relay[k]) begin
        relay[k] = want_on[k];
        if (relay[k]) begin
          on_at[k]      = b.now_ms;
          lowflow_at[k] = '0;
        end else begin
          offflow_at[k] = '0;
        end
      end
    end

    r.pump1_relay_on     = relay[0];
    r.pump2_relay_on     = relay[1];
    r.pump1_status       = status_bits(0);
    r.pump2_status       = status_bits(1);
    r.tank_flags         = tank_bits;
    r.system_error       = err;
    r.pump1_total_pulses = total[0];
    r.pump2_total_pulses = total[1];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", field, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DRYRUN_GRACE:   grace_ms       = cfg_data;
          REG_DRYRUN_TIMEOUT: dry_ms         = cfg_data;
          REG_STUCK_TIMEOUT:  stuck_ms       = cfg_data;
          REG_MIN_FLOW_RATE:  min_rate       = cfg_data[RATE_W-1:0];
          REG_STUCK_FLOW:     stuck_rate     = cfg_data[RATE_W-1:0];
          REG_TANK_LOW_RAW:   tank_low       = cfg_data[TANK_CFG_W-1:0];
          REG_TANK_MODE:      tank_by_switch = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          oldest = status_due.pop_front();
          check_field("pump1_relay_on", oldest.pump1_relay_on, out_data.pump1_relay_on);
          check_field("pump2_relay_on", oldest.pump2_relay_on, out_data.pump2_relay_on);
          check_field("pump1_status", oldest.pump1_status, out_data.pump1_status);
          check_field("pump2_status", oldest.pump2_status, out_data.pump2_status);
          check_field("tank_flags", oldest.tank_flags, out_data.tank_flags);
          check_field("system_error", oldest.system_error, out_data.system_error);
          check_field("pump1_total_pulses", oldest.pump1_total_pulses,
                      out_data.pump1_total_pulses);
          check_field("pump2_total_pulses", oldest.pump2_total_pulses,
                      out_data.pump2_total_pulses);
        end
      end
      if (in_valid && in_ready) status_due.push_back(supervise(in_data));
    end
    pending = status_due.size();
  end

endmodule

// ===== tb/sv/tb_pump_protection_supervisor.sv =====
// testbench top of the pump protection supervisor: stimulus, handshake pressure and verdict
`timescale 1ns / 1ps

module tb_pump_protection_supervisor;
  import ppsup_pkg::*;

  localparam logic [CFG_IDX_W-1:0] BAD_REG_INDEX = 3'd7;
  localparam int PHASE_BEATS = 220;
  localparam int SOAK_BEATS  = 32;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    pending;
  int                    fails;

  // copies of the settings in force, to aim the random beats
  logic [RATE_W-1:0]     cur_min = RST_MIN_RATE;
  logic [RATE_W-1:0]     cur_stk = RST_STK_RATE;
  logic [TANK_CFG_W-1:0] cur_tlow = RST_TANK_LOW;
  logic                  cur_mode = 1'b0;
  logic [31:0]           clock_ms = '0;
  int                    burst_left = 0;
  logic [7:0]            stall_cnt = '0;
  logic [1:0]            stall_mode = '0;
  in_t                   soak_beat;

  always #2 clk = ~clk;

  pump_protection_supervisor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pump_supervisor_check checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fails     (fails)
  );

  // receiver: switches, whenever the low six bits of stall_cnt wrap to zero, between no stalls, a fixed stall pattern,
  // random stalls and long on/off stretches
  always @(posedge clk) begin
    stall_cnt = stall_cnt + 8'd1;
    if (stall_cnt[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= (stall_cnt[2:0] != 3'd5) && (stall_cnt[2:0] != 3'd6);
      2'd2:    out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= stall_cnt[3];
    endcase
  end

  initial begin
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

  task automatic send_beat(input in_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] grace, dto, sto,
                            input logic [RATE_W-1:0] minr, stkr,
                            input logic [TANK_CFG_W-1:0] tlow, input logic mode);
    write_reg(REG_DRYRUN_GRACE, grace);
    write_reg(REG_DRYRUN_TIMEOUT, dto);
    write_reg(REG_STUCK_TIMEOUT, sto);
    write_reg(REG_MIN_FLOW_RATE, 16'(minr));
    write_reg(REG_STUCK_FLOW, 16'(stkr));
    write_reg(REG_TANK_LOW_RAW, 16'(tlow));
    write_reg(REG_TANK_MODE, 16'(mode));
    cfg_we   <= 1'b0;
    cur_min  = minr;
    cur_stk  = stkr;
    cur_tlow = tlow;
    cur_mode = mode;
  endtask

  function automatic in_t mk_tick(input logic [31:0] now, el, input logic [15:0] p1, p2,
                                  input logic [ADC_BITS-1:0] raw, input logic sw);
    in_t b;
    b.req_type        = REQ_TICK;
    b.now_ms          = now;
    b.elapsed_ms      = el;
    b.pulses_pump1    = p1;
    b.pulses_pump2    = p2;
    b.tank_raw        = raw;
    b.tank_switch_low = sw;
    b.pump_select     = 1'($urandom);
    b.pump_on         = 1'($urandom);
    return b;
  endfunction

  // sensor fields of a command carry noise, the block must ignore them
  function automatic in_t mk_cmd(input logic [31:0] now, input logic sel, on);
    in_t b;
    b.req_type        = REQ_CMD;
    b.now_ms          = now;
    b.elapsed_ms      = $urandom;
    b.pulses_pump1    = 16'($urandom);
    b.pulses_pump2    = 16'($urandom);
    b.tank_raw        = ADC_BITS'($urandom);
    b.tank_switch_low = 1'($urandom);
    b.pump_select     = sel;
    b.pump_on         = on;
    return b;
  endfunction

  // pulse counts clustered round the low-flow and stuck thresholds
  function automatic logic [15:0] rand_pulses(input logic [31:0] el);
    logic [63:0]       knee;
    logic [RATE_W-1:0] rate;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return 16'd0;
    if (pick < 30) return 16'($urandom);
    rate = (pick < 65) ? cur_min : cur_stk;
    knee = (64'(rate) * 64'(el)) / 64'(FLOW_SCALE) + 64'($urandom_range(0, 4));
    knee = (knee < 64'd2) ? 64'd0 : knee - 64'd2;
    return (knee > 64'd65535) ? 16'hFFFF : knee[15:0];
  endfunction

  function automatic in_t rand_beat();
    in_t         b;
    int unsigned pick;
    logic [31:0] el_eff;
    pick = $urandom_range(0, 99);
    if (pick < 80)      clock_ms = clock_ms + $urandom_range(0, 2500);
    else if (pick < 90) clock_ms = clock_ms + $urandom_range(0, 20000);
    else if (pick < 95) clock_ms = $urandom;
    else if (pick < 98) clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
    else                clock_ms = '0;
    b.now_ms      = clock_ms;
    b.req_type    = ($urandom_range(0, 3) == 0) ? REQ_CMD : REQ_TICK;
    b.pump_select = 1'($urandom);
    b.pump_on     = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 65)      b.elapsed_ms = $urandom_range(500, 1500);
    else if (pick < 75) b.elapsed_ms = '0;
    else if (pick < 85) b.elapsed_ms = $urandom;
    else if (pick < 90) b.elapsed_ms = 32'd60000;
    else                b.elapsed_ms = $urandom_range(1, 60000);
    el_eff = (b.elapsed_ms == 32'd0) ? DEFAULT_ELAPSED : b.elapsed_ms;
    b.pulses_pump1 = rand_pulses(el_eff);
    b.pulses_pump2 = rand_pulses(el_eff);
    // keep the level interlock mostly released so pumps get to run
    if (!cur_mode && cur_tlow != '1 && $urandom_range(0, 99) < 88)
      b.tank_raw = ADC_BITS'($urandom_range(4095, 32'(cur_tlow) + 1));
    else
      b.tank_raw = ADC_BITS'($urandom);
    b.tank_switch_low = cur_mode ? ($urandom_range(0, 99) < 8) : 1'($urandom);
    return b;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats with the reset settings
    send_beat(mk_tick(32'd0, 32'd0, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_cmd(32'd0, 1'b0, 1'b1));
    send_beat(mk_tick(32'd1000, 32'd1000, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_tick(32'd4000, 32'd1000, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_tick(32'd12000, 32'd1000, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_cmd(32'd12500, 1'b1, 1'b1));
    send_beat(mk_tick(32'd13000, 32'd1000, 16'hFFFF, 16'd3, 12'd2000, 1'b0));
    send_beat(mk_tick(32'd18000, 32'd1000, 16'hFFFF, 16'd3, 12'd2000, 1'b0));
    // pulse counts exactly on both thresholds
    send_beat(mk_tick(32'd19000, 32'd60000, 16'd135, 16'd225, 12'd2000, 1'b0));
    send_beat(mk_cmd(32'd20000, 1'b0, 1'b1));
    send_beat(mk_tick(32'd24000, 32'd1000, 16'd10, 16'd10, 12'd2000, 1'b0));
    send_beat(mk_tick(32'd25000, 32'd1000, 16'd10, 16'd10, 12'd992, 1'b0));
    send_beat(mk_tick(32'd26000, 32'd1000, 16'd10, 16'd10, 12'd993, 1'b0));
    send_beat(mk_tick(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 12'd0, 1'b1));
    send_beat(mk_tick(32'hFFFF_FF10, 32'd16, 16'd5, 16'd5, 12'hFFF, 1'b1));
    send_beat(mk_cmd(32'hFFFF_FFF0, 1'b1, 1'b1));
    send_beat(mk_cmd(32'hFFFF_FFFF, 1'b0, 1'b1));
    // time wraps past zero while both pumps run
    send_beat(mk_tick(32'h0000_0100, 32'h110, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_tick(32'd0, 32'd1000, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_tick(32'd5000, 32'd1000, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_tick(32'd12000, 32'd1000, 16'd0, 16'd0, 12'hFFF, 1'b0));
    send_beat(mk_cmd(32'd13000, 1'b0, 1'b0));
    send_beat(mk_cmd(32'd13000, 1'b1, 1'b0));
    send_beat(mk_tick(32'd14000, 32'd1000, 16'd1, 16'd1, 12'hFFF, 1'b1));
    clock_ms = 32'd30000;

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(BAD_REG_INDEX, 16'hFFFF);
          set_config(RST_GRACE, RST_DRY_TIMEOUT, RST_STK_TIMEOUT, RST_MIN_RATE,
                     RST_STK_RATE, RST_TANK_LOW, 1'b0);
        end
        1: set_config($urandom_range(0, 4000), $urandom_range(0, 9000),
                      $urandom_range(0, 6000), $urandom_range(20, 400),
                      $urandom_range(50, 700), $urandom_range(200, 3000), 1'b0);
        2: set_config('0, '0, '0, '0, '0, '0, 1'b1);
        3: set_config('1, '1, '1, '1, '1, '1, 1'b1);
        4: set_config($urandom_range(0, 4000), $urandom_range(0, 9000),
                      $urandom_range(0, 6000), $urandom_range(20, 400),
                      $urandom_range(50, 700), $urandom_range(0, 4095), 1'b1);
        5: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
        // level interlock held for good
        6: set_config($urandom_range(0, 4000), $urandom_range(0, 9000),
                      $urandom_range(0, 6000), $urandom_range(20, 400),
                      $urandom_range(50, 700), '1, 1'b0);
        default: set_config($urandom_range(0, 4000), $urandom_range(0, 9000),
                            $urandom_range(0, 6000), $urandom_range(20, 400),
                            $urandom_range(50, 700), '0, 1'b0);
      endcase
      repeat (PHASE_BEATS) send_beat(rand_beat());
    end

    // a short run of ticks with full-scale pulse counts
    wait_idle();
    set_config(RST_GRACE, RST_DRY_TIMEOUT, RST_STK_TIMEOUT, RST_MIN_RATE,
               RST_STK_RATE, RST_TANK_LOW, 1'b0);
    repeat (SOAK_BEATS) begin
      soak_beat = rand_beat();
      soak_beat.req_type     = REQ_TICK;
      soak_beat.pulses_pump1 = '1;
      soak_beat.pulses_pump2 = '1;
      send_beat(soak_beat);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ppsup_pkg.sv
sv/ppsup_flow.sv
sv/ppsup_pump.sv
sv/pump_protection_supervisor.sv
tb/sv/pump_supervisor_check.sv
tb/sv/tb_pump_protection_supervisor.sv
